// ----- src/average_true_range_filter_macros.svh -----
// Assertion macros for the average true range filter.
`ifndef AVERAGE_TRUE_RANGE_FILTER_MACROS_SVH
`define AVERAGE_TRUE_RANGE_FILTER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ATR_ASSERT_AT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
`define ATR_ASSERT_NEXT(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (prop)) \
        else $error(msg);
`else
`define ATR_ASSERT_AT(lbl, prop, msg)
`define ATR_ASSERT_NEXT(lbl, cond, prop, msg)
`endif
`endif

// ----- src/atr_pkg.sv -----
// Types and constants shared by the average true range filter modules.
package atr_pkg;

    localparam int PRICE_BITS = 32;
    localparam int LEN_W      = 7;
    localparam int LEN_MAX    = 2**LEN_W - 1;
    localparam int MODE_W     = 2;
    localparam int FRAC_BITS  = 16;
    localparam int VALUE_W    = PRICE_BITS + FRAC_BITS;
    localparam int PLAIN_W    = PRICE_BITS + LEN_W;
    // n*(n+1)/2 for n up to LEN_MAX
    localparam int TRI_W      = 2*LEN_W - 1;
    localparam int WSUM_W     = PRICE_BITS + TRI_W;
    localparam int EPROD_W    = VALUE_W + LEN_W;
    localparam int NUM_W      = 64;
    localparam int DEN_W      = 14;
    localparam int DIV_STEP   = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_AVG_MODE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN = 1'b1;

    localparam logic [MODE_W-1:0] MODE_SIMPLE   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_WEIGHTED = 2'd1;
    localparam logic [MODE_W-1:0] MODE_EXP      = 2'd2;
    localparam logic [MODE_W-1:0] MODE_WILDER   = 2'd3;

    localparam logic [MODE_W-1:0] RESET_MODE = MODE_WILDER;
    localparam logic [LEN_W-1:0]  RESET_LEN  = 7'd14;

    typedef struct packed {
        logic                  series_start;
        logic [PRICE_BITS-1:0] bar_high;
        logic [PRICE_BITS-1:0] bar_low;
        logic [PRICE_BITS-1:0] bar_close;
    } t_bar_in;

    typedef struct packed {
        logic [VALUE_W-1:0] atr_value;
        logic               atr_valid;
    } t_atr_out;

    typedef struct packed {
        logic load_bar;
        logic calc_range;
        logic sums;
        logic div_start;
        logic div_avg;
        logic ema_upd;
        logic res_zero;
        logic res_ema;
        logic res_quot;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic have_prev;
        logic seeded;
        logic full;
        logic avg_from_ema;
        logic div_busy;
        logic div_done;
        logic out_free;
    } t_dp_sts;

endpackage

// ----- src/atr_div.sv -----
// Serial restoring divider, several quotient bits per cycle.
module atr_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [atr_pkg::NUM_W-1:0]  i_num,
    input  logic [atr_pkg::DEN_W-1:0]  i_den,
    output logic                       o_busy,
    output logic                       o_done,
    output logic [atr_pkg::NUM_W-1:0]  o_quot
);

    localparam int NUM_W = atr_pkg::NUM_W;
    localparam int DEN_W = atr_pkg::DEN_W;
    localparam int ITER  = NUM_W / atr_pkg::DIV_STEP;
    localparam int CNT_W = $clog2(ITER);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_num;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W-1:0] r_rem;
    logic [NUM_W-1:0] n_num;
    logic [DEN_W-1:0] n_rem;

    // Dividend shifts out at the top while quotient bits shift in at the bottom
    always_comb begin
        logic [DEN_W:0] trial;
        n_num = r_num;
        n_rem = r_rem;
        for (int s = 0; s < atr_pkg::DIV_STEP; s++) begin
            trial = {n_rem, n_num[NUM_W-1]};
            n_num = {n_num[NUM_W-2:0], 1'b0};
            if (trial >= {1'b0, r_den}) begin
                n_rem    = DEN_W'(trial - {1'b0, r_den});
                n_num[0] = 1'b1;
            end else begin
                n_rem = trial[DEN_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(ITER - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= n_num;
            r_rem <= n_rem;
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_num;

endmodule

// ----- src/atr_dp.sv -----
// Datapath: range window, running sums, EMA, divider and output register.
module atr_dp #(
    parameter int MAX_WINDOW = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [atr_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [atr_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  atr_pkg::t_bar_in                i_in_word,
    input  atr_pkg::t_dp_cmd                i_cmd,
    output atr_pkg::t_dp_sts                o_sts,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output atr_pkg::t_atr_out               o_out_word
);

    localparam int PRICE_BITS = atr_pkg::PRICE_BITS;
    localparam int LEN_W      = atr_pkg::LEN_W;
    localparam int VALUE_W    = atr_pkg::VALUE_W;
    localparam int PLAIN_W    = atr_pkg::PLAIN_W;
    localparam int WSUM_W     = atr_pkg::WSUM_W;
    localparam int EPROD_W    = atr_pkg::EPROD_W;
    localparam int TRI_W      = atr_pkg::TRI_W;
    localparam int NUM_W      = atr_pkg::NUM_W;
    localparam int DEN_W      = atr_pkg::DEN_W;
    localparam int FRAC_BITS  = atr_pkg::FRAC_BITS;
    localparam int IDX_W      = $clog2(MAX_WINDOW);
    localparam int LEN_CAP    = (MAX_WINDOW < atr_pkg::LEN_MAX) ? MAX_WINDOW : atr_pkg::LEN_MAX;
    localparam int SPAN_W     = ((IDX_W > LEN_W) ? IDX_W : LEN_W) + 1;

    logic [atr_pkg::MODE_W-1:0] r_mode;
    logic [LEN_W-1:0]           r_wlen;
    atr_pkg::t_bar_in           r_bar;
    logic [PRICE_BITS-1:0]      r_prev_close;
    logic                       r_have_prev;
    logic [IDX_W-1:0]           r_head;
    logic [LEN_W-1:0]           r_count;
    logic [PLAIN_W-1:0]         r_plain;
    logic [WSUM_W-1:0]          r_weighted;
    logic [VALUE_W-1:0]         r_ema;
    logic                       r_seeded;
    logic [PRICE_BITS-1:0]      r_tr;
    logic [PRICE_BITS-1:0]      r_old;
    logic [EPROD_W-1:0]         r_eprod;
    atr_pkg::t_atr_out          r_res;
    logic                       r_out_valid;
    atr_pkg::t_atr_out          r_out;
    logic [PRICE_BITS-1:0]      r_mem [MAX_WINDOW];

    logic                  s_clear;
    logic                  s_wilder;
    logic [LEN_W-1:0]      s_len;
    logic [LEN_W:0]        s_len_p1;
    logic                  s_full;
    logic [SPAN_W-1:0]     s_head_w;
    logic [SPAN_W-1:0]     s_len_w;
    logic [IDX_W-1:0]      s_old_idx;
    logic [IDX_W-1:0]      s_head_n;
    logic [PRICE_BITS-1:0] s_d_hc;
    logic [PRICE_BITS-1:0] s_d_lc;
    logic [PRICE_BITS-1:0] s_hl;
    logic [PRICE_BITS-1:0] s_tr_a;
    logic [PRICE_BITS-1:0] s_tr;
    logic [LEN_W-1:0]      s_wmul;
    logic [PLAIN_W-1:0]    s_wprod;
    logic [WSUM_W-1:0]     s_weighted_n;
    logic [PLAIN_W-1:0]    s_plain_n;
    logic [VALUE_W-1:0]    s_trq;
    logic [2*LEN_W:0]      s_tri_x2;
    logic [TRI_W-1:0]      s_tri;
    logic [LEN_W:0]        s_ema_den;
    logic [NUM_W-1:0]      s_ema_num;
    logic [DEN_W-1:0]      s_avg_den;
    logic [NUM_W-1:0]      s_avg_num;
    logic [NUM_W-1:0]      s_div_num;
    logic [DEN_W-1:0]      s_div_den;
    logic                  s_div_busy;
    logic                  s_div_done;
    logic [NUM_W-1:0]      s_quot;

    assign s_clear  = i_cfg_we || (i_cmd.load_bar && i_in_word.series_start);
    assign s_wilder = (r_mode == atr_pkg::MODE_WILDER);

    // Clamp window length into 1..LEN_CAP (the smaller of MAX_WINDOW and LEN_MAX)
    always_comb begin
        if (r_wlen == '0) begin
            s_len = LEN_W'(1);
        end else if (r_wlen > LEN_W'(LEN_CAP)) begin
            s_len = LEN_W'(LEN_CAP);
        end else begin
            s_len = r_wlen;
        end
    end

    assign s_len_p1 = {1'b0, s_len} + 1'b1;
    assign s_full   = (r_count >= s_len);

    // Oldest slot sits n entries behind the write head
    assign s_head_w  = SPAN_W'(r_head);
    assign s_len_w   = SPAN_W'(s_len);
    assign s_old_idx = (s_head_w >= s_len_w) ? IDX_W'(s_head_w - s_len_w)
                     : IDX_W'(s_head_w + SPAN_W'(MAX_WINDOW) - s_len_w);
    assign s_head_n  = (r_head == IDX_W'(MAX_WINDOW - 1)) ? '0 : r_head + 1'b1;

    // True range
    assign s_d_hc = (r_bar.bar_high >= r_prev_close) ? r_bar.bar_high - r_prev_close
                  : r_prev_close - r_bar.bar_high;
    assign s_d_lc = (r_bar.bar_low >= r_prev_close) ? r_bar.bar_low - r_prev_close
                  : r_prev_close - r_bar.bar_low;
    assign s_hl   = r_bar.bar_high - r_bar.bar_low;
    assign s_tr_a = (s_d_lc > s_d_hc) ? s_d_lc : s_d_hc;
    assign s_tr   = ((r_bar.bar_high > r_bar.bar_low) && (s_hl > s_tr_a)) ? s_hl : s_tr_a;

    // Running sums
    assign s_wmul       = s_full ? s_len : r_count + 1'b1;
    assign s_wprod      = PLAIN_W'(s_wmul) * PLAIN_W'(r_tr);
    assign s_weighted_n = s_full ? r_weighted - WSUM_W'(r_plain) + WSUM_W'(s_wprod)
                        : r_weighted + WSUM_W'(s_wprod);
    assign s_plain_n    = s_full ? r_plain - PLAIN_W'(r_old) + PLAIN_W'(r_tr)
                        : r_plain + PLAIN_W'(r_tr);
    assign s_trq        = {r_tr, {FRAC_BITS{1'b0}}};

    // Divider operands, rounding half up by adding half the divisor
    assign s_ema_den = s_wilder ? {1'b0, s_len} : s_len_p1;
    assign s_ema_num = NUM_W'(r_eprod)
                     + (s_wilder ? NUM_W'(s_trq) : (NUM_W'(s_trq) << 1))
                     + NUM_W'(s_ema_den >> 1);
    assign s_tri_x2  = (2*LEN_W+1)'(s_len) * (2*LEN_W+1)'(s_len_p1);
    assign s_tri     = s_tri_x2[TRI_W:1];
    assign s_avg_den = (r_mode == atr_pkg::MODE_SIMPLE) ? DEN_W'(s_len) : DEN_W'(s_tri);
    assign s_avg_num = ((r_mode == atr_pkg::MODE_SIMPLE) ? (NUM_W'(r_plain) << FRAC_BITS)
                                                         : (NUM_W'(r_weighted) << FRAC_BITS))
                     + NUM_W'(s_avg_den >> 1);
    assign s_div_num = i_cmd.div_avg ? s_avg_num : s_ema_num;
    assign s_div_den = i_cmd.div_avg ? s_avg_den : DEN_W'(s_ema_den);

    atr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (s_div_num),
        .i_den   (s_div_den),
        .o_busy  (s_div_busy),
        .o_done  (s_div_done),
        .o_quot  (s_quot)
    );

    // Configuration and series state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= atr_pkg::RESET_MODE;
            r_wlen       <= atr_pkg::RESET_LEN;
            r_prev_close <= '0;
            r_have_prev  <= 1'b0;
            r_head       <= '0;
            r_count      <= '0;
            r_plain      <= '0;
            r_weighted   <= '0;
            r_ema        <= '0;
            r_seeded     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    atr_pkg::CFG_AVG_MODE:   r_mode <= i_cfg_data[atr_pkg::MODE_W-1:0];
                    atr_pkg::CFG_WINDOW_LEN: r_wlen <= i_cfg_data[LEN_W-1:0];
                    default: ;
                endcase
            end
            if (s_clear) begin
                r_prev_close <= '0;
                r_have_prev  <= 1'b0;
                r_head       <= '0;
                r_count      <= '0;
                r_plain      <= '0;
                r_weighted   <= '0;
                r_ema        <= '0;
                r_seeded     <= 1'b0;
            end
            if (i_cmd.sums) begin
                r_weighted <= s_weighted_n;
                r_plain    <= s_plain_n;
                r_head     <= s_head_n;
                if (!s_full) begin
                    r_count <= r_count + 1'b1;
                end
                // First range seeds the EMA directly
                if (!r_seeded) begin
                    r_ema    <= s_trq;
                    r_seeded <= 1'b1;
                end
            end
            if (i_cmd.ema_upd) begin
                r_ema <= s_quot[VALUE_W-1:0];
            end
            if (i_cmd.out_load) begin
                r_prev_close <= r_bar.bar_close;
                r_have_prev  <= 1'b1;
            end
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_bar) begin
            r_bar <= i_in_word;
        end
        if (i_cmd.calc_range) begin
            r_tr <= s_tr;
        end
        if (i_cmd.sums) begin
            r_eprod <= EPROD_W'(r_ema) * EPROD_W'(s_len - 1'b1);
        end
        if (i_cmd.res_zero) begin
            r_res <= '0;
        end else if (i_cmd.res_ema) begin
            r_res.atr_value <= r_ema;
            r_res.atr_valid <= 1'b1;
        end else if (i_cmd.res_quot) begin
            r_res.atr_value <= s_quot[VALUE_W-1:0];
            r_res.atr_valid <= 1'b1;
        end
    end

    // Range window: read the oldest entry before the new one overwrites it
    always_ff @(posedge i_clk) begin
        if (i_cmd.sums) begin
            r_mem[r_head] <= r_tr;
        end
        if (i_cmd.calc_range) begin
            r_old <= r_mem[s_old_idx];
        end
    end

    // Output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    assign o_sts.have_prev    = r_have_prev;
    assign o_sts.seeded       = r_seeded;
    assign o_sts.full         = s_full;
    assign o_sts.avg_from_ema = (r_mode == atr_pkg::MODE_EXP) || s_wilder;
    assign o_sts.div_busy     = s_div_busy;
    assign o_sts.div_done     = s_div_done;
    assign o_sts.out_free     = !r_out_valid || !i_out_stall;

endmodule

// ----- src/atr_ctrl.sv -----
// Controller: sequences one price bar through the datapath.
module atr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  atr_pkg::t_dp_sts  i_sts,
    output atr_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_CHECK = 9'b000000010,
        S_RANGE = 9'b000000100,
        S_SUMS  = 9'b000001000,
        S_EGO   = 9'b000010000,
        S_EWAIT = 9'b000100000,
        S_AVG   = 9'b001000000,
        S_AWAIT = 9'b010000000,
        S_DONE  = 9'b100000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_bar = 1'b1;
                    n_state        = S_CHECK;
                end
            end
            S_CHECK: begin
                // First bar of a series gives no range
                if (i_sts.have_prev) begin
                    n_state = S_RANGE;
                end else begin
                    o_cmd.res_zero = 1'b1;
                    n_state        = S_DONE;
                end
            end
            S_RANGE: begin
                o_cmd.calc_range = 1'b1;
                n_state          = S_SUMS;
            end
            S_SUMS: begin
                o_cmd.sums = 1'b1;
                n_state    = i_sts.seeded ? S_EGO : S_AVG;
            end
            S_EGO: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_EWAIT;
            end
            S_EWAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.ema_upd = 1'b1;
                    n_state       = S_AVG;
                end
            end
            S_AVG: begin
                if (!i_sts.full) begin
                    o_cmd.res_zero = 1'b1;
                    n_state        = S_DONE;
                end else if (i_sts.avg_from_ema) begin
                    o_cmd.res_ema = 1'b1;
                    n_state       = S_DONE;
                end else begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_avg   = 1'b1;
                    n_state         = S_AWAIT;
                end
            end
            S_AWAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.res_quot = 1'b1;
                    n_state        = S_DONE;
                end
            end
            S_DONE: begin
                // Hold the result until the output register frees up
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

// ----- src/average_true_range_filter.sv -----
// Top level of the average true range filter.
//
//   channel   signals                                    word
//   input     i_in_valid / o_in_stall                    t_bar_in  (series_start, high, low, close)
//   output    o_out_valid / i_out_stall                  t_atr_out (atr_value Q32.16, atr_valid)
//   config    i_cfg_we, i_cfg_idx, i_cfg_data            avg_mode (0), window_len (1)
//
// One bar at a time: the first bar of a series goes straight to a zero result; later bars
// run the EMA update division, then the mean division when a full window in simple or
// weighted mode needs it; the bar that seeds the EMA skips the update division.
// The serial divider produces 4 quotient bits per cycle.
// Synchronous active-low reset; the range window needs no clearing pass.
// A stalled output word holds in its register while the next bar is taken in.
`include "average_true_range_filter_macros.svh"

module average_true_range_filter #(
    parameter int MAX_WINDOW = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [atr_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [atr_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  atr_pkg::t_bar_in                i_in_word,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output atr_pkg::t_atr_out               o_out_word
);

    atr_pkg::t_dp_cmd s_cmd;
    atr_pkg::t_dp_sts s_sts;

    atr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (s_sts),
        .o_cmd      (s_cmd)
    );

    atr_dp #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_word   (i_in_word),
        .i_cmd       (s_cmd),
        .o_sts       (s_sts),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    `ATR_ASSERT_AT(a_div_start_idle, !(s_cmd.div_start && s_sts.div_busy), "divider restarted while busy")
    `ATR_ASSERT_AT(a_out_load_free, !(s_cmd.out_load && !s_sts.out_free), "output word overwritten")
    `ATR_ASSERT_NEXT(a_one_bar, i_in_valid && !o_in_stall, o_in_stall, "second bar taken while busy")

endmodule
